>>> hdl/io_region_map_decoder_core_defines.svh
// assertion macros of the region decoder core
`ifndef IO_REGION_MAP_DECODER_CORE_DEFINES_SVH
`define IO_REGION_MAP_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define IORM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("region decoder check failed");
`define IORM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("region decoder forbidden condition seen");
`else
`define IORM_ASSERT(lbl, clk, rst, prop)
`define IORM_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

>>> hdl/iorm_pkg.sv
// types and codes of the io region map decoder
package iorm_pkg;

   localparam int NUM_SLOTS_DEFAULT = 16;
   // slot numbers travel at the width of the largest table
   localparam int SLOT_IDX_W = 8;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_OVERLAP = 2'd2;
   localparam logic [1:0] ST_NODEV   = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] address;
      logic [31:0] length;
      logic [63:0] write_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_index;
      logic [63:0] offset;
      logic        is_write;
      logic [63:0] forward_data;
   } rsp_type;

   // request walking along the row of slot cells, with its running results
   typedef struct packed {
      logic                  valid;
      logic [1:0]            action;
      logic [63:0]           address;
      logic [63:0]           end_addr;
      logic [63:0]           write_data;
      logic                  free_found;
      logic [SLOT_IDX_W-1:0] free_idx;
      logic                  overlap;
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_idx;
      logic [63:0]           hit_base;
   } token_type;

   // slot table update broadcast to all cells
   typedef struct packed {
      logic                  add_en;
      logic                  clear;
      logic [SLOT_IDX_W-1:0] idx;
      logic [63:0]           base;
      logic [63:0]           end_addr;
   } upd_type;

endpackage

>>> hdl/io_region_map_decoder_core.sv
// io region map decoder: table of address regions with add, clear and access decode
//
// request channel (req_): one transfer carries an action (add region, read access,
// write access, clear all), an address, a length and write data
// result channel (rsp_): one transfer per request with status, slot index, offset
// from the region base, write flag and forwarded write data
// a request walks the row of slot cells, one cell per cycle, each cell holding one
// region; the request passes the entry register and then each cell register, and
// the result is then loaded into the output register at the end of the row
// one request is in flight at a time: req_stall is high from the transfer until the
// result is loaded, so a new request is not taken before the last one is through
// add and clear update the table when the result is loaded, before the next request
// the result sits in an output register; while rsp_stall holds it, the finished
// request waits at the end of the row and further requests stay stalled
// reset empties the table (all slots free) and drops any request in flight
module io_region_map_decoder_core #(
   parameter int NUM_SLOTS = iorm_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iorm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iorm_pkg::rsp_type rsp_data
);
   import iorm_pkg::*;

`include "io_region_map_decoder_core_defines.svh"

   // control
   logic      busy_ff;
   logic      busy_in;
   logic      accept;
   logic      fire;
   logic      out_free;
   logic      hold;

   // request entering the row
   token_type entry_ff;
   token_type entry_in;

   // tokens between cells, index 0 is the entry register
   token_type tok [NUM_SLOTS+1];
   logic [NUM_SLOTS:0] tok_valid;
   token_type last;

   // table update and result
   upd_type   upd;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign accept   = req_valid && !busy_ff;
   assign last     = tok[NUM_SLOTS];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = last.valid && out_free;
   assign hold     = last.valid && !out_free;

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // busy from request transfer until its result is loaded
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (fire) begin
         busy_in = 1'b0;
      end
   end

   // build the walking token; end sum wraps at 64 bits
   always_comb begin
      entry_in            = entry_ff;
      entry_in.valid      = accept;
      if (accept) begin
         entry_in.action     = req_data.action;
         entry_in.address    = req_data.address;
         entry_in.end_addr   = req_data.address + {32'd0, req_data.length};
         entry_in.write_data = req_data.write_data;
         entry_in.free_found = 1'b0;
         entry_in.free_idx   = '0;
         entry_in.overlap    = 1'b0;
         entry_in.hit        = 1'b0;
         entry_in.hit_idx    = '0;
         entry_in.hit_base   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         entry_ff.valid <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         entry_ff <= entry_in;
      end
   end

   assign tok[0]       = entry_ff;
   assign tok_valid[0] = entry_ff.valid;

   // row of slot cells
   for (genvar gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
      iorm_cell #(
         .CELL_INDEX (gi)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .hold     (hold),
         .upd      (upd),
         .tok_prev (tok[gi]),
         .tok_out  (tok[gi+1])
      );
      assign tok_valid[gi+1] = tok[gi+1].valid;
   end

   // finish: form the result and the table update from the walked token
   always_comb begin
      rsp_data_in = '0;
      upd         = '0;
      upd.idx     = last.free_idx;
      upd.base    = last.address;
      upd.end_addr = last.end_addr;
      case (last.action)
         ACT_ADD: begin
            if (!last.free_found) begin
               rsp_data_in.status = ST_FULL;
            end else if (last.overlap) begin
               rsp_data_in.status = ST_OVERLAP;
            end else begin
               rsp_data_in.status     = ST_OK;
               rsp_data_in.slot_index = last.free_idx[3:0];
               upd.add_en             = fire;
            end
         end
         ACT_CLEAR: begin
            rsp_data_in.status = ST_OK;
            upd.clear          = fire;
         end
         ACT_READ, ACT_WRITE: begin
            if (last.hit) begin
               rsp_data_in.status     = ST_OK;
               rsp_data_in.slot_index = last.hit_idx[3:0];
               rsp_data_in.offset     = last.address - last.hit_base;
               if (last.action == ACT_WRITE) begin
                  rsp_data_in.is_write     = 1'b1;
                  rsp_data_in.forward_data = last.write_data;
               end
            end else begin
               rsp_data_in.status = ST_NODEV;
            end
         end
         default: begin
            rsp_data_in.status = ST_NODEV;
         end
      endcase
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks
   // only one request walks the row at a time
   `IORM_ASSERT(a_one_token, clock, reset, $onehot0(tok_valid))
   // a request transfer makes the block busy
   `IORM_ASSERT(a_busy_after_req, clock, reset, (req_valid && !req_stall) |=> req_stall)
   // leaving busy means a result was just loaded
   `IORM_ASSERT(a_done_has_rsp, clock, reset, $fell(busy_ff) |-> rsp_valid_ff)
   // a write flag only comes with a hit
   `IORM_ASSERT_NEVER(a_write_ok, clock, reset,
      rsp_valid_ff && rsp_data_ff.is_write && (rsp_data_ff.status != ST_OK))

endmodule

>>> hdl/iorm_cell.sv
// one slot of the region table, checks the passing request against its region
module iorm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                hold,
   input  iorm_pkg::upd_type   upd,
   input  iorm_pkg::token_type tok_prev,
   output iorm_pkg::token_type tok_out
);
   import iorm_pkg::*;

   localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_INDEX);

   logic        valid_ff;
   logic [63:0] base_ff;
   logic [63:0] end_ff;
   token_type   tok_ff;
   token_type   tok_in;
   logic        write_me;

   assign write_me = upd.add_en && (upd.idx == MY_IDX);

   always_comb begin
      tok_in = tok_prev;
      // lowest free slot
      if (!valid_ff && !tok_prev.free_found) begin
         tok_in.free_found = 1'b1;
         tok_in.free_idx   = MY_IDX;
      end
      // half-open intersection with the new region
      if (valid_ff && (tok_prev.end_addr > base_ff) && (tok_prev.address < end_ff)) begin
         tok_in.overlap = 1'b1;
      end
      // lowest slot holding the whole access
      if (valid_ff && !tok_prev.hit && (tok_prev.address >= base_ff) &&
          (tok_prev.end_addr <= end_ff)) begin
         tok_in.hit      = 1'b1;
         tok_in.hit_idx  = MY_IDX;
         tok_in.hit_base = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (!hold) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (upd.clear) begin
         valid_ff <= 1'b0;
      end else if (write_me) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write_me) begin
         base_ff <= upd.base;
         end_ff  <= upd.end_addr;
      end
   end

   assign tok_out = tok_ff;

endmodule
